// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the allocator.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFLA_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sfla: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFLA_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sfla: assertion failed");

`endif

// ===== rtl/sfla_pkg.sv =====
// Shared types and constants of the segregated free-list allocator.
// No dependencies; used by the controller, the datapath and the top level.
package sfla_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned ADDR_W        = 13;
  localparam int unsigned SIZE_W        = 16;
  localparam int unsigned CIU_W         = 7;
  localparam int unsigned LIMIT_W       = 14;
  localparam int unsigned COUNT_W       = 14;
  localparam int unsigned GRANULE_SHIFT = 3;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 14;

  localparam int unsigned NUM_CLASSES_DEF   = 64;
  localparam int unsigned POOL_GRANULES_DEF = 8192;
  localparam int unsigned HDR_GRANULES_DEF  = 2;

  localparam logic [CIU_W-1:0]   CIU_RST   = 7'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 14'd8192;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_BAD_CLASS = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASSES_IN_USE = 1'b0,
    CFG_POOL_LIMIT     = 1'b1
  } cfg_idx_e;

  // One free-list descriptor per size class.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  tail;
    logic [ADDR_W-1:0]  head;
  } list_ent_t;

  localparam int unsigned LIST_W = $bits(list_ent_t);

  typedef struct packed {
    logic    load;          // latch the accepted request
    logic    list_rd_size;  // read list entry of the class given by the size
    logic    hcls_rd;       // read header class of the freed block
    logic    list_rd_hdr;   // read list entry of the class from the header
    logic    clear_next;    // clear next link of the freed block
    logic    hnxt_rd;       // read next link of the list head
    logic    bump;          // bump allocation, result
    logic    pop;           // pop list head, result
    logic    append;        // append at list tail, result
    logic    err;           // error result
    status_e err_code;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_bad;
    logic addr_bad;
    logic head_empty;
    logic space_ok;
    logic cls_bad;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/sfla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sfla_ctrl.sv =====
// Request sequencer of the allocator: walks each request through its steps.
// Depends on sfla_pkg for the command and status structs.
module sfla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sfla_pkg::sts_t sts_i,
  output sfla_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC_LIST,
    S_POP,
    S_FREE_CLS,
    S_FREE_APPEND
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Steps that produce a result wait for a free output register and
  // only then commit their writes.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_free) begin
          if (sts_i.addr_bad) begin
            if (sts_i.out_free) begin
              cmd_o.err      = 1'b1;
              cmd_o.err_code = sfla_pkg::ST_BAD_CLASS;
              state_d        = S_IDLE;
            end
          end else begin
            cmd_o.hcls_rd = 1'b1;
            state_d       = S_FREE_CLS;
          end
        end else begin
          if (sts_i.size_bad) begin
            if (sts_i.out_free) begin
              cmd_o.err      = 1'b1;
              cmd_o.err_code = sfla_pkg::ST_BAD_SIZE;
              state_d        = S_IDLE;
            end
          end else begin
            cmd_o.list_rd_size = 1'b1;
            state_d            = S_ALLOC_LIST;
          end
        end
      end
      S_ALLOC_LIST: begin
        if (!sts_i.head_empty) begin
          cmd_o.hnxt_rd = 1'b1;
          state_d       = S_POP;
        end else if (sts_i.out_free) begin
          if (sts_i.space_ok) begin
            cmd_o.bump = 1'b1;
          end else begin
            cmd_o.err      = 1'b1;
            cmd_o.err_code = sfla_pkg::ST_NO_SPACE;
          end
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (sts_i.out_free) begin
          cmd_o.pop = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_FREE_CLS: begin
        if (sts_i.cls_bad) begin
          if (sts_i.out_free) begin
            cmd_o.err      = 1'b1;
            cmd_o.err_code = sfla_pkg::ST_BAD_CLASS;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.list_rd_hdr = 1'b1;
          cmd_o.clear_next  = 1'b1;
          state_d           = S_FREE_APPEND;
        end
      end
      S_FREE_APPEND: begin
        if (sts_i.out_free) begin
          cmd_o.append = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/sfla_datapath.sv =====
// Allocator datapath: request and config registers, list and header RAMs,
// bump pointer and result register. Depends on sfla_pkg and sfla_ram.
module sfla_datapath #(
  parameter int unsigned NUM_CLASSES   = sfla_pkg::NUM_CLASSES_DEF,
  parameter int unsigned POOL_GRANULES = sfla_pkg::POOL_GRANULES_DEF,
  parameter int unsigned HDR_GRANULES  = sfla_pkg::HDR_GRANULES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sfla_pkg::cmd_t                   cmd_i,
  output sfla_pkg::sts_t                   sts_o,
  input  logic                             req_kind_i,
  input  logic [sfla_pkg::SIZE_W-1:0]      req_size_i,
  input  logic [sfla_pkg::ADDR_W-1:0]      req_addr_i,
  input  logic                             cfg_valid_i,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfla_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [sfla_pkg::ADDR_W-1:0]      res_addr_o,
  output logic [1:0]                       res_status_o
);

  localparam int unsigned CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned ADDR_SPAN = 2 ** sfla_pkg::ADDR_W;
  localparam int unsigned HDR_DEPTH = (POOL_GRANULES < ADDR_SPAN) ? POOL_GRANULES
                                                                  : ADDR_SPAN;
  localparam int unsigned HDR_AW    = $clog2(HDR_DEPTH);
  localparam int unsigned BUMP_W    = sfla_pkg::LIMIT_W + 1;
  localparam int unsigned CLSF_W    = sfla_pkg::SIZE_W - sfla_pkg::GRANULE_SHIFT;

  // Request, config and bump registers.
  logic                           kind_q;
  logic [sfla_pkg::SIZE_W-1:0]    size_q;
  logic [sfla_pkg::ADDR_W-1:0]    addr_q;
  logic [CLS_W-1:0]               cls_q, cls_d;
  logic [sfla_pkg::CIU_W-1:0]     ciu_q;
  logic [sfla_pkg::LIMIT_W-1:0]   limit_q;
  logic [sfla_pkg::LIMIT_W-1:0]   bump_q;
  logic                           res_valid_q;
  logic [sfla_pkg::ADDR_W-1:0]    res_addr_q, res_addr_d;
  logic [1:0]                     res_status_q, res_status_d;

  // RAM ports.
  logic                           list_we, list_re;
  logic [CLS_W-1:0]               list_raddr;
  sfla_pkg::list_ent_t            list_wdata;
  logic [sfla_pkg::LIST_W-1:0]    list_rdata;
  logic [NUM_CLASSES-1:0]         list_vld_q;
  logic                           list_rvld_q;
  sfla_pkg::list_ent_t            ent;

  logic                           hcls_we;
  logic [CLS_W-1:0]               hcls_rdata;
  logic                           hnxt_we;
  logic [HDR_AW-1:0]              hnxt_waddr;
  logic [sfla_pkg::ADDR_W-1:0]    hnxt_wdata;
  logic [sfla_pkg::ADDR_W-1:0]    hnxt_rdata;

  // Decode and arithmetic.
  logic [sfla_pkg::SIZE_W-1:0]    size_m1;
  logic [CLSF_W-1:0]              cls_full;
  logic [BUMP_W-1:0]              bump_sum, bump_data, limit_eff;
  logic                           finish;

  assign size_m1  = size_q - sfla_pkg::SIZE_W'(1);
  assign cls_full = size_m1[sfla_pkg::SIZE_W-1:sfla_pkg::GRANULE_SHIFT];

  assign ent = list_rvld_q ? sfla_pkg::list_ent_t'(list_rdata) : '0;

  assign bump_data = BUMP_W'(bump_q) + BUMP_W'(HDR_GRANULES);
  assign bump_sum  = bump_data + BUMP_W'(cls_q) + BUMP_W'(1);
  assign limit_eff = (32'(limit_q) < POOL_GRANULES) ? BUMP_W'(limit_q)
                                                    : BUMP_W'(POOL_GRANULES);

  always_comb begin
    sts_o.is_free    = kind_q;
    sts_o.size_bad   = (size_q == '0) || (32'(cls_full) >= 32'(ciu_q))
                       || (32'(cls_full) >= NUM_CLASSES);
    sts_o.addr_bad   = (32'(addr_q) < HDR_GRANULES) || (32'(addr_q) >= POOL_GRANULES);
    sts_o.head_empty = (ent.head == '0);
    sts_o.space_ok   = (bump_sum <= limit_eff);
    sts_o.cls_bad    = (32'(hcls_rdata) >= 32'(ciu_q)) || (32'(hcls_rdata) >= NUM_CLASSES);
    sts_o.out_free   = !res_valid_q || res_ready_i;
  end

  // List descriptor RAM: read at the request's class, written on pop/append.
  assign list_re    = cmd_i.list_rd_size || cmd_i.list_rd_hdr;
  assign list_raddr = cmd_i.list_rd_size ? cls_full[CLS_W-1:0] : hcls_rdata;
  assign list_we    = cmd_i.pop || cmd_i.append;

  always_comb begin
    list_wdata = ent;
    if (cmd_i.pop) begin
      if (hnxt_rdata == '0) begin
        list_wdata = '0;
      end else begin
        list_wdata.head = hnxt_rdata;
        if (ent.count != '0) begin
          list_wdata.count = ent.count - sfla_pkg::COUNT_W'(1);
        end
      end
    end else begin
      if (ent.head == '0) begin
        list_wdata.head = addr_q;
      end
      list_wdata.tail = addr_q;
      if (ent.count != sfla_pkg::COUNT_MAX) begin
        list_wdata.count = ent.count + sfla_pkg::COUNT_W'(1);
      end
    end
  end

  sfla_ram #(
    .WIDTH (sfla_pkg::LIST_W),
    .DEPTH (NUM_CLASSES)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (cls_q),
    .wdata_i (list_wdata),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  // Header class RAM, written when a block is carved from the bump region.
  assign hcls_we = cmd_i.bump && (32'(bump_data) < HDR_DEPTH);

  sfla_ram #(
    .WIDTH (CLS_W),
    .DEPTH (HDR_DEPTH)
  ) u_hcls_ram (
    .clk_i   (clk_i),
    .we_i    (hcls_we),
    .waddr_i (bump_data[HDR_AW-1:0]),
    .wdata_i (cls_q),
    .re_i    (cmd_i.hcls_rd),
    .raddr_i (addr_q[HDR_AW-1:0]),
    .rdata_o (hcls_rdata)
  );

  // Next-link RAM: cleared for the freed block, then linked from the old tail.
  always_comb begin
    hnxt_we    = 1'b0;
    hnxt_waddr = addr_q[HDR_AW-1:0];
    hnxt_wdata = '0;
    if (cmd_i.clear_next) begin
      hnxt_we = 1'b1;
    end else if (cmd_i.append && (ent.head != '0)) begin
      hnxt_we    = 1'b1;
      hnxt_waddr = ent.tail[HDR_AW-1:0];
      hnxt_wdata = addr_q;
    end
  end

  sfla_ram #(
    .WIDTH (sfla_pkg::ADDR_W),
    .DEPTH (HDR_DEPTH)
  ) u_hnxt_ram (
    .clk_i   (clk_i),
    .we_i    (hnxt_we),
    .waddr_i (hnxt_waddr),
    .wdata_i (hnxt_wdata),
    .re_i    (cmd_i.hnxt_rd),
    .raddr_i (ent.head[HDR_AW-1:0]),
    .rdata_o (hnxt_rdata)
  );

  always_comb begin
    cls_d = cls_q;
    if (cmd_i.list_rd_size) begin
      cls_d = cls_full[CLS_W-1:0];
    end else if (cmd_i.list_rd_hdr) begin
      cls_d = hcls_rdata;
    end
  end

  assign finish = cmd_i.bump || cmd_i.pop || cmd_i.append || cmd_i.err;

  always_comb begin
    res_addr_d   = '0;
    res_status_d = sfla_pkg::ST_OK;
    if (cmd_i.err) begin
      res_status_d = cmd_i.err_code;
    end else if (cmd_i.bump) begin
      res_addr_d = bump_data[sfla_pkg::ADDR_W-1:0];
    end else if (cmd_i.pop) begin
      res_addr_d = ent.head;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_kind_i;
      size_q <= req_size_i;
      addr_q <= req_addr_i;
    end
    cls_q <= cls_d;
    if (finish) begin
      res_addr_q   <= res_addr_d;
      res_status_q <= res_status_d;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ciu_q       <= sfla_pkg::CIU_RST;
      limit_q     <= sfla_pkg::LIMIT_RST;
      bump_q      <= sfla_pkg::LIMIT_W'(1);
      list_vld_q  <= '0;
      list_rvld_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (sfla_pkg::cfg_idx_e'(cfg_index_i))
          sfla_pkg::CFG_CLASSES_IN_USE: ciu_q   <= cfg_data_i[sfla_pkg::CIU_W-1:0];
          sfla_pkg::CFG_POOL_LIMIT:     limit_q <= cfg_data_i[sfla_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.bump) begin
        bump_q <= bump_sum[sfla_pkg::LIMIT_W-1:0];
      end
      if (list_we) begin
        list_vld_q[cls_q] <= 1'b1;
      end
      if (list_re) begin
        list_rvld_q <= list_vld_q[list_raddr];
      end
      if (finish) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_addr_o   = res_addr_q;
  assign res_status_o = res_status_q;

endmodule

// ===== rtl/segregated_free_list_allocator_unit.sv =====
// Segregated free-list allocator over a pool of 8-byte granules.
// Input stream: one request per item; tuser selects allocate (0) or free (1),
// tdata carries the byte size and the data granule address of the block.
// Output stream: one result per request, data granule address in tdata and
// a status code in tuser (ok, bad size, out of space, bad class).
// Config channel: cfg_index_i 0 sets classes in use, 1 sets the pool limit;
// always ready, writes take effect on the next cycle; the user must write only
// while idle, the block itself does not enforce it. Size and address errors
// end in the decode step, bump allocation and bad header classes in the step
// after it, list pops and frees after a further read (list, then next link;
// header class, then list). One request is in flight at a time; a new request
// can be taken in the cycle after the previous one finishes. A pending result
// may wait in the output register while the next request is accepted; that
// request stalls on its final step until the result is taken.
// Reset empties every free list (per-class valid bits), sets the bump pointer
// to granule 1 and the config registers to their defaults; no clearing pass.
module segregated_free_list_allocator_unit #(
  parameter int unsigned NUM_CLASSES   = sfla_pkg::NUM_CLASSES_DEF,
  parameter int unsigned POOL_GRANULES = sfla_pkg::POOL_GRANULES_DEF,
  parameter int unsigned HDR_GRANULES  = sfla_pkg::HDR_GRANULES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // request_size, block_address
  input  logic [0:0]                      s_axis_tuser,  // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // data_address
  output logic [1:0]                      m_axis_tuser,  // status
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfla_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sfla_pkg::cmd_t              cmd;
  sfla_pkg::sts_t              sts;
  logic [sfla_pkg::ADDR_W-1:0] res_addr;

  assign cfg_ready_o = 1'b1;

  sfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfla_datapath #(
    .NUM_CLASSES   (NUM_CLASSES),
    .POOL_GRANULES (POOL_GRANULES),
    .HDR_GRANULES  (HDR_GRANULES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_kind_i   (s_axis_tuser[0]),
    .req_size_i   (s_axis_tdata[15:0]),
    .req_addr_i   (s_axis_tdata[28:16]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_addr_o   (res_addr),
    .res_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, res_addr};

endmodule

// ===== rtl/sfla_checker.sv =====
// Port-level checks of the allocator, bound to the top level.
// Depends on assert_macros.svh and sfla_pkg.
`include "assert_macros.svh"

module sfla_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result holds.
  `SFLA_ASSERT_NXT(a_res_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Any error reports address zero.
  `SFLA_ASSERT_IMP(a_err_addr, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != sfla_pkg::ST_OK), m_axis_tdata == 16'd0)

  // One request at a time: after an accepted request the input is closed.
  `SFLA_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A new result comes only out of a request in progress.
  `SFLA_ASSERT_IMP(a_res_from_busy, clk_i, rst_ni, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind segregated_free_list_allocator_unit sfla_checker u_sfla_checker (.*);

// ===== test/segregated_free_list_allocator_unit_tb.sv =====
// Testbench for the segregated free-list allocator: directed requests, then
// random allocate/free traffic checked against an in-bench allocator model.
// Depends on sfla_pkg and segregated_free_list_allocator_unit only.
module segregated_free_list_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADDR_W        = sfla_pkg::ADDR_W;
  localparam int unsigned SIZE_W        = sfla_pkg::SIZE_W;
  localparam int unsigned COUNT_W       = sfla_pkg::COUNT_W;
  localparam int unsigned CFG_IDX_W     = sfla_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W    = sfla_pkg::CFG_DATA_W;
  localparam int unsigned GRANULE_SHIFT = sfla_pkg::GRANULE_SHIFT;
  localparam int unsigned NCLS          = sfla_pkg::NUM_CLASSES_DEF;
  localparam int unsigned POOL          = sfla_pkg::POOL_GRANULES_DEF;
  localparam int unsigned HDR           = sfla_pkg::HDR_GRANULES_DEF;
  localparam int unsigned GRANULE_BYTES = 8;
  localparam logic        KIND_ALLOC    = 1'b0;
  localparam logic        KIND_FREE     = 1'b1;
  localparam int unsigned NEAR_FULL     = 0;  // phase limit: just above the bump mark
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    sfla_pkg::status_e st;
  } grant_t;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              known;
    logic [ADDR_W-1:0] want_addr;
    sfla_pkg::status_e want_st;
  } probe_t;

  typedef struct {
    int unsigned classes;
    int unsigned limit;
    int unsigned items;
    int unsigned send_idle;
    int unsigned recv_idle;
  } phase_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;  // request_size, block_address
  logic [0:0]            s_axis_tuser = '0;  // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;       // data_address
  logic [1:0]            m_axis_tuser;       // status
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  segregated_free_list_allocator_unit DUT (.*);

  always #1 clk_i = ~clk_i;

  // Allocator model state
  int unsigned         model_classes = sfla_pkg::CIU_RST;
  int unsigned         model_limit   = sfla_pkg::LIMIT_RST;
  int unsigned         model_bump    = 1;
  logic [ADDR_W-1:0]   class_head  [NCLS] = '{default: '0};
  logic [ADDR_W-1:0]   class_tail  [NCLS] = '{default: '0};
  logic [COUNT_W-1:0]  class_count [NCLS] = '{default: '0};
  logic [5:0]          hdr_class   [POOL] = '{default: '0};
  logic [ADDR_W-1:0]   hdr_next    [POOL] = '{default: '0};

  grant_t              expected_grants[$];
  logic [ADDR_W-1:0]   live_blocks[$];    // handed out, not freed since
  logic [ADDR_W-1:0]   issued_blocks[$];  // every bump-allocated block
  int                  mismatch_count = 0;
  int unsigned         send_idle_pct  = 27;
  int unsigned         recv_idle_pct  = 69;
  int unsigned         hold_left      = 0;
  bit                  long_hold_done = 1'b0;
  int unsigned         results_seen   = 0;

  probe_t probe_rows [23] = '{
    '{KIND_ALLOC, 16'd0,     13'h1FFF, 1'b1, 13'd0,  sfla_pkg::ST_BAD_SIZE},
    '{KIND_ALLOC, 16'hFFFF,  13'd0,    1'b1, 13'd0,  sfla_pkg::ST_BAD_SIZE},
    '{KIND_ALLOC, 16'd513,   13'd0,    1'b1, 13'd0,  sfla_pkg::ST_BAD_SIZE},
    '{KIND_ALLOC, 16'd1,     13'd0,    1'b1, 13'd3,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd512,   13'd0,    1'b1, 13'd6,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd8,     13'd0,    1'b1, 13'd72, sfla_pkg::ST_OK},
    '{KIND_FREE,  16'hFFFF,  13'd0,    1'b1, 13'd0,  sfla_pkg::ST_BAD_CLASS},
    '{KIND_FREE,  16'd0,     13'd1,    1'b1, 13'd0,  sfla_pkg::ST_BAD_CLASS},
    '{KIND_FREE,  16'd0,     13'd3,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_FREE,  16'd0,     13'd72,   1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_FREE,  16'd0,     13'd6,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd5,     13'd0,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd7,     13'd0,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd9,     13'd0,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd500,   13'd0,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_FREE,  16'd0,     13'd79,   1'b0, 13'd0,  sfla_pkg::ST_OK},
    // same block again: the class list links back onto itself
    '{KIND_FREE,  16'd0,     13'd79,   1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd497,   13'd0,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd497,   13'd0,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_FREE,  16'd0,     13'd75,   1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd16,    13'd0,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd512,   13'd0,    1'b0, 13'd0,  sfla_pkg::ST_OK},
    '{KIND_ALLOC, 16'd8191,  13'd0,    1'b1, 13'd0,  sfla_pkg::ST_BAD_SIZE}
  };

  phase_t phases [6] = '{
    '{64, 8192,      160, 27, 69},
    '{1,  4096,      40,  27, 69},
    '{8,  1,         30,  69, 27},
    '{20, NEAR_FULL, 50,  69, 27},
    '{33, 8192,      100, 69, 27},
    '{64, 8192,      110, 0,  0}
  };

  function automatic bit class_accepted(int unsigned cls);
    return cls < model_classes && cls < NCLS;
  endfunction

  function automatic void predict_allocation(input logic kind, input logic [SIZE_W-1:0] size,
                                             input logic [ADDR_W-1:0] addr,
                                             output grant_t res, output bit bumped);
    int unsigned cls, blk, cap;
    logic [ADDR_W-1:0] nxt;
    res    = '{addr: '0, st: sfla_pkg::ST_OK};
    bumped = 1'b0;
    if (kind == KIND_ALLOC) begin
      cls = ((32'(size) + GRANULE_BYTES - 1) >> GRANULE_SHIFT) - 1;
      if (size == '0 || !class_accepted(cls)) begin
        res.st = sfla_pkg::ST_BAD_SIZE;
      end else if (class_head[cls] != '0) begin
        res.addr        = class_head[cls];
        nxt             = hdr_next[res.addr];
        class_head[cls] = nxt;
        if (nxt == '0) begin
          class_tail[cls]  = '0;
          class_count[cls] = '0;
        end else if (class_count[cls] != '0) begin
          class_count[cls]--;
        end
      end else begin
        blk = HDR + cls + 1;
        cap = (model_limit < POOL) ? model_limit : POOL;
        if (model_bump + blk > cap) begin
          res.st = sfla_pkg::ST_NO_SPACE;
        end else begin
          res.addr           = ADDR_W'(model_bump + HDR);
          hdr_class[res.addr] = 6'(cls);
          model_bump         += blk;
          bumped              = 1'b1;
        end
      end
    end else begin
      if (addr < HDR || addr >= POOL || !class_accepted(hdr_class[addr])) begin
        res.st = sfla_pkg::ST_BAD_CLASS;
      end else begin
        cls           = hdr_class[addr];
        hdr_next[addr] = '0;
        if (class_head[cls] == '0) begin
          class_head[cls] = addr;
        end else begin
          hdr_next[class_tail[cls]] = addr;
        end
        class_tail[cls] = addr;
        if (class_count[cls] != sfla_pkg::COUNT_MAX) class_count[cls]++;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one request and return at the edge where it is taken.
  task automatic send_request(logic kind, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, addr, size};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Send, predict, queue the expected grant and track block ownership.
  task automatic issue_request(logic kind, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr,
                               bit known, grant_t typed);
    grant_t res;
    bit     bumped;
    send_request(kind, size, addr);
    predict_allocation(kind, size, addr, res, bumped);
    expected_grants.push_back(known ? typed : res);
    if (res.st != sfla_pkg::ST_OK) return;
    if (kind == KIND_ALLOC) begin
      live_blocks.push_back(res.addr);
      if (bumped) issued_blocks.push_back(res.addr);
    end else begin
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == addr) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic random_request();
    int unsigned r, pick, max_bytes;
    logic              kind;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    max_bytes = GRANULE_BYTES * ((model_classes < NCLS) ? model_classes : NCLS);
    kind = KIND_ALLOC;
    size = SIZE_W'($urandom);
    addr = ADDR_W'($urandom);
    r    = $urandom_range(99);
    if (r < 46 || issued_blocks.size() == 0) begin
      pick = $urandom_range(99);
      if (pick < 60)      size = SIZE_W'($urandom_range((max_bytes < 64) ? max_bytes : 64, 1));
      else if (pick < 85) size = SIZE_W'($urandom_range(max_bytes, 1));
      else if (pick < 90) size = '0;
      else if (pick < 95) size = SIZE_W'(max_bytes + $urandom_range(16, 1));
      else                size = SIZE_W'($urandom_range(65535));
    end else if (r < 90 && live_blocks.size() != 0) begin
      kind = KIND_FREE;
      addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
    end else if (r < 96) begin
      // addresses inside the reserved header area
      kind = KIND_FREE;
      addr = ADDR_W'($urandom_range(HDR - 1));
    end else begin
      // any block ever handed out, possibly already free
      kind = KIND_FREE;
      addr = issued_blocks[$urandom_range(issued_blocks.size() - 1)];
    end
    issue_request(kind, size, addr, 1'b0, '0);
  endtask

  task automatic wait_idle();
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_limits(int unsigned classes, int unsigned limit);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sfla_pkg::CFG_CLASSES_IN_USE;
    cfg_data_i  <= CFG_DATA_W'(classes);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= sfla_pkg::CFG_POOL_LIMIT;
    cfg_data_i  <= CFG_DATA_W'(limit);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    model_classes = classes & 32'h7F;
    model_limit   = limit & 32'h3FFF;
  endtask

  // Result side: check every grant, random back-pressure plus one long hold.
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result, data_address", m_axis_tdata, -1);
        end else begin
          want = expected_grants.pop_front();
          if (m_axis_tdata != {3'b000, want.addr})
            report_mismatch("data_address", m_axis_tdata, want.addr);
          if (m_axis_tuser != want.st)
            report_mismatch("status", m_axis_tuser, want.st);
        end
      end
      if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1'b1;
        hold_left      = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #400000;
    $display("segregated_free_list_allocator_unit_tb failed");
    $finish;
  end

  initial begin
    int unsigned limit;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (probe_rows[i])
      issue_request(probe_rows[i].kind, probe_rows[i].size, probe_rows[i].addr,
                    probe_rows[i].known, '{probe_rows[i].want_addr, probe_rows[i].want_st});
    s_axis_tvalid <= 1'b0;

    foreach (phases[p]) begin
      wait_idle();
      limit = phases[p].limit;
      if (limit == NEAR_FULL) limit = (model_bump + 40 < POOL) ? model_bump + 40 : POOL;
      program_limits(phases[p].classes, limit);
      send_idle_pct = phases[p].send_idle;
      recv_idle_pct = phases[p].recv_idle;
      repeat (phases[p].items) random_request();
      s_axis_tvalid <= 1'b0;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("segregated_free_list_allocator_unit_tb passed");
    end else begin
      $display("segregated_free_list_allocator_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sfla_pkg.sv
rtl/sfla_ram.sv
rtl/sfla_ctrl.sv
rtl/sfla_datapath.sv
rtl/segregated_free_list_allocator_unit.sv
rtl/sfla_checker.sv
test/segregated_free_list_allocator_unit_tb.sv
